### src/bfsk_pkg.sv
// bfsk_pkg: shared types and constants of the bfsk tone modulator
`default_nettype none
package bfsk_pkg;

  // input kind codes
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_BIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_FOR_ZERO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_FOR_ONE    = 2'd2;
  localparam int unsigned CFG_DATA_W = 32;

  // register reset values (44.1 kHz sample clock, 1 kHz / 2 kHz tones)
  localparam logic [15:0] SPB_RESET       = 16'd4410;
  localparam logic [31:0] STEP_ZERO_RESET = 32'd97391548;
  localparam logic [31:0] STEP_ONE_RESET  = 32'd194783097;

  // bits per byte
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // sine polynomial coefficients, q30
  localparam logic [31:0] Q30_ONE    = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
  localparam logic [30:0] COEF_A     = 31'd1686629713;
  localparam logic [29:0] COEF_B     = 30'd688904866;
  localparam logic [26:0] COEF_C     = 27'd76016977;
  localparam logic [14:0] SAMPLE_MAX = 15'd32767;
  localparam logic [47:0] ROUND_HALF = 48'd536870912;

  // request queue between phase front and sine back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // one sample request: phase to look up and its flags
  typedef struct packed {
    logic [31:0] phase;
    logic        active;
    logic        last;
  } tone_req_t;

  // flags carried along the sine pipeline
  typedef struct packed {
    logic neg;
    logic active;
    logic last;
  } tone_tag_t;

endpackage
`default_nettype wire

### src/bfsk_tone_modulator_unit.sv
// bfsk_tone_modulator_unit: binary fsk tone generator, top level
`default_nettype none
// Binary FSK modulator. A load request (tuser 0) takes a byte from tdata and
// sends it msb first; each tick request (tuser 1) returns one signed q1.15
// sine sample. A 1 bit uses step_for_one and a 0 bit step_for_zero as the
// per-sample phase increment; the phase restarts at zero at the start of
// every bit, and each bit lasts samples_per_bit ticks (0 acts as 1). A tick
// while idle returns a zero sample with tuser low; a load while busy is
// dropped. tlast marks the final sample of a byte. The front accepts one
// request per clock while the queue has room; ticks go through a 4-deep
// queue into a 6-stage sine pipeline (a fold stage, four multiply stages
// of a polynomial sine and a scaling stage), and without output stalls
// the sustained rate is one request per clock. Backpressure on the output
// stalls the sine pipeline; the front keeps taking requests until
// the queue fills. SINE_TABLE_ENTRIES sets the phase quantization and must be
// a power of two. Configuration writes take effect on the next clock and are
// meant for idle periods; indexes beyond step_for_one are ignored.
module bfsk_tone_modulator_unit #(
  parameter int unsigned SINE_TABLE_ENTRIES = 1024
) (
  input  wire                             clk,
  input  wire                             rst_n,
  // configuration
  input  wire                             cfg_we,
  input  wire [bfsk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [bfsk_pkg::CFG_DATA_W-1:0]  cfg_data,
  // request channel
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire [7:0]                       in_tdata,   // [7:0] byte_value
  input  wire                             in_tuser,   // [0] kind
  // sample channel
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [15:0]                     out_tdata,  // [15:0] sample
  output logic                            out_tuser,  // [0] active
  output logic                            out_tlast   // last_of_byte
);

  logic                in_fire;
  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_empty;
  logic                busy;
  bfsk_pkg::tone_req_t push_req;
  bfsk_pkg::tone_req_t head_req;

  // queue space is the only thing that holds off requests
  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  // bit sequencing and phase
  bfsk_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_fire    (in_fire),
    .kind       (in_tuser),
    .byte_value (in_tdata),
    .push       (q_push),
    .push_req   (push_req),
    .busy       (busy)
  );

  // decouples the front from output stalls
  bfsk_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_req (push_req),
    .full     (q_full),
    .pop      (q_pop),
    .head_req (head_req),
    .empty    (q_empty)
  );

  // sine evaluation and output register
  bfsk_sine #(
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
  ) u_sine (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_req   (head_req),
    .head_valid (!q_empty),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (out_tdata),
    .out_active (out_tuser),
    .out_last   (out_tlast)
  );

`ifndef SYNTH
  // a tick never arrives at a full queue
  assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
    else $error("request pushed into full queue");

  // end of byte only on an active sample
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("last of byte on idle sample");

  // idle samples are silent
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 16'd0)
    else $error("idle sample not zero");

  // the sender only goes idle after queuing the last sample of a byte
  assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> $past(q_push && push_req.last))
    else $error("busy cleared without last sample");
`endif

endmodule
`default_nettype wire

### src/bfsk_queue.sv
// bfsk_queue: short request fifo between the phase front and the sine back
`default_nettype none
module bfsk_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  bfsk_pkg::tone_req_t  push_req,
  output logic                 full,
  input  wire                  pop,
  output bfsk_pkg::tone_req_t  head_req,
  output logic                 empty
);

  bfsk_pkg::tone_req_t slot_r [bfsk_pkg::QUEUE_DEPTH];
  logic [bfsk_pkg::QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [bfsk_pkg::QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [bfsk_pkg::QUEUE_CW-1:0] count_r, count_nxt;

  assign full     = (count_r == bfsk_pkg::QUEUE_CW'(bfsk_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign head_req = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

endmodule
`default_nettype wire

### src/bfsk_front.sv
// bfsk_front: configuration registers, bit sequencing and phase accumulation
`default_nettype none
module bfsk_front (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [bfsk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [bfsk_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                              in_fire,
  input  wire                              kind,
  input  wire [7:0]                        byte_value,
  output logic                             push,
  output bfsk_pkg::tone_req_t              push_req,
  output logic                             busy
);

  logic [15:0] spb_r;
  logic [31:0] step_zero_r;
  logic [31:0] step_one_r;

  logic [7:0]  shifter_r, shifter_nxt;
  logic [3:0]  bits_left_r, bits_left_nxt;
  logic [15:0] count_r, count_nxt;
  logic [31:0] phase_r, phase_nxt;
  logic        busy_r, busy_nxt;

  logic        is_tick;
  logic        is_load;
  logic [15:0] count_inc;
  logic [15:0] limit;
  logic        bit_end;
  logic [31:0] step;

  assign is_tick   = in_fire && (kind == bfsk_pkg::KIND_TICK);
  assign is_load   = in_fire && (kind == bfsk_pkg::KIND_LOAD);
  assign count_inc = count_r + 16'd1;
  assign limit     = (spb_r == '0) ? 16'd1 : spb_r;
  // count wrap also ends the bit
  assign bit_end   = (count_inc >= limit) || (count_inc == '0);
  assign step      = shifter_r[7] ? step_one_r : step_zero_r;

  assign push            = is_tick;
  assign push_req.phase  = busy_r ? phase_r : '0;
  assign push_req.active = busy_r;
  assign push_req.last   = busy_r && bit_end && (bits_left_r == 4'd1);
  assign busy            = busy_r;

  always_comb begin
    shifter_nxt   = shifter_r;
    bits_left_nxt = bits_left_r;
    count_nxt     = count_r;
    phase_nxt     = phase_r;
    busy_nxt      = busy_r;
    if (is_load && !busy_r) begin
      shifter_nxt   = byte_value;
      bits_left_nxt = bfsk_pkg::BITS_PER_BYTE;
      count_nxt     = '0;
      phase_nxt     = '0;
      busy_nxt      = 1'b1;
    end else if (is_tick && busy_r) begin
      if (bit_end) begin
        count_nxt     = '0;
        phase_nxt     = '0;
        shifter_nxt   = {shifter_r[6:0], 1'b0};
        bits_left_nxt = bits_left_r - 4'd1;
        if (bits_left_r == 4'd1) begin
          busy_nxt = 1'b0;
        end
      end else begin
        count_nxt = count_inc;
        phase_nxt = phase_r + step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spb_r       <= bfsk_pkg::SPB_RESET;
      step_zero_r <= bfsk_pkg::STEP_ZERO_RESET;
      step_one_r  <= bfsk_pkg::STEP_ONE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bfsk_pkg::REG_SAMPLES_PER_BIT: spb_r       <= cfg_data[15:0];
        bfsk_pkg::REG_STEP_FOR_ZERO:   step_zero_r <= cfg_data;
        bfsk_pkg::REG_STEP_FOR_ONE:    step_one_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shifter_r   <= '0;
      bits_left_r <= '0;
      count_r     <= '0;
      phase_r     <= '0;
      busy_r      <= 1'b0;
    end else begin
      shifter_r   <= shifter_nxt;
      bits_left_r <= bits_left_nxt;
      count_r     <= count_nxt;
      phase_r     <= phase_nxt;
      busy_r      <= busy_nxt;
    end
  end

endmodule
`default_nettype wire

### src/bfsk_sine.sv
// bfsk_sine: pipelined fixed-point sine evaluation with output register
`default_nettype none
module bfsk_sine #(
  parameter int unsigned SINE_TABLE_ENTRIES = 1024
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  bfsk_pkg::tone_req_t  head_req,
  input  wire                  head_valid,
  output logic                 pop,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [15:0]          out_sample,
  output logic                 out_active,
  output logic                 out_last
);

  localparam int unsigned IDX_W = $clog2(SINE_TABLE_ENTRIES);

  logic en;

  // stage 1: quantized and folded angle
  logic [31:0] angle;
  logic [31:0] half_angle;
  logic [31:0] folded;
  logic [30:0] x_s1;
  bfsk_pkg::tone_tag_t tag_s1;
  logic v_s1;

  // stage 2: x squared
  logic [61:0] m_xx;
  logic [30:0] x_s2, sq_s2;
  bfsk_pkg::tone_tag_t tag_s2;
  logic v_s2;

  // stage 3: inner coefficient
  logic [57:0] m_c;
  logic [29:0] t_nxt;
  logic [30:0] x_s3, sq_s3;
  logic [29:0] t_s3;
  bfsk_pkg::tone_tag_t tag_s3;
  logic v_s3;

  // stage 4: outer coefficient
  logic [60:0] m_t;
  logic [30:0] t2_nxt;
  logic [30:0] x_s4, t2_s4;
  bfsk_pkg::tone_tag_t tag_s4;
  logic v_s4;

  // stage 5: q30 sine value
  logic [61:0] m_y;
  logic [31:0] y_s5;
  bfsk_pkg::tone_tag_t tag_s5;
  logic v_s5;

  // stage 6: scaled and signed sample
  logic [47:0] m_s;
  logic [17:0] mag_wide;
  logic [14:0] mag;
  logic [15:0] sample_nxt;
  logic [15:0] sample_r;
  logic        active_r, last_r;
  logic        out_valid_r;

  assign en  = !out_valid_r || out_ready;
  assign pop = en && head_valid;

  assign angle      = {head_req.phase[31 -: IDX_W], {(32 - IDX_W){1'b0}}};
  assign half_angle = {1'b0, angle[30:0]};
  assign folded     = (half_angle > bfsk_pkg::Q30_ONE) ?
                      (bfsk_pkg::HALF_TURN - half_angle) : half_angle;

  assign m_xx   = 62'(x_s1) * 62'(x_s1);
  assign m_c    = 58'(sq_s2) * 58'(bfsk_pkg::COEF_C);
  assign t_nxt  = bfsk_pkg::COEF_B - 30'(m_c[57:30]);
  assign m_t    = 61'(sq_s3) * 61'(t_s3);
  assign t2_nxt = bfsk_pkg::COEF_A - m_t[60:30];
  assign m_y    = 62'(x_s4) * 62'(t2_s4);

  assign m_s      = 48'(y_s5) * 48'(bfsk_pkg::SAMPLE_MAX) + bfsk_pkg::ROUND_HALF;
  assign mag_wide = m_s[47:30];
  assign mag      = (mag_wide > 18'(bfsk_pkg::SAMPLE_MAX)) ? bfsk_pkg::SAMPLE_MAX
                                                           : mag_wide[14:0];
  always_comb begin
    if (!tag_s5.active) begin
      sample_nxt = '0;
    end else if (tag_s5.neg) begin
      sample_nxt = 16'd0 - {1'b0, mag};
    end else begin
      sample_nxt = {1'b0, mag};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_s1        <= 1'b0;
      v_s2        <= 1'b0;
      v_s3        <= 1'b0;
      v_s4        <= 1'b0;
      v_s5        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_s1        <= head_valid;
      v_s2        <= v_s1;
      v_s3        <= v_s2;
      v_s4        <= v_s3;
      v_s5        <= v_s4;
      out_valid_r <= v_s5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_s1          <= folded[30:0];
      tag_s1.neg    <= angle[31];
      tag_s1.active <= head_req.active;
      tag_s1.last   <= head_req.last;

      x_s2   <= x_s1;
      sq_s2  <= m_xx[60:30];
      tag_s2 <= tag_s1;

      x_s3   <= x_s2;
      sq_s3  <= sq_s2;
      t_s3   <= t_nxt;
      tag_s3 <= tag_s2;

      x_s4   <= x_s3;
      t2_s4  <= t2_nxt;
      tag_s4 <= tag_s3;

      y_s5   <= m_y[61:30];
      tag_s5 <= tag_s4;

      sample_r <= sample_nxt;
      active_r <= tag_s5.active;
      last_r   <= tag_s5.last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = sample_r;
  assign out_active = active_r;
  assign out_last   = last_r;

endmodule
`default_nettype wire

### tb/tb_bfsk_tone_modulator_unit.sv
// self-checking testbench for the bfsk tone modulator unit
module tb_bfsk_tone_modulator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // sine table size shared by the dut and the local tone predictor
  localparam longint unsigned TABLE_N = 1024;

  // index past the last register, writes to it must be dropped
  localparam logic [bfsk_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // polynomial sine constants in q30
  localparam longint unsigned QUARTER_TURN = 64'd1073741824;
  localparam longint unsigned POLY_A = 64'd1686629713;
  localparam longint unsigned POLY_B = 64'd688904866;
  localparam longint unsigned POLY_C = 64'd76016977;
  localparam longint unsigned PEAK = 64'd32767;

  // clocks of queue plus sine pipeline, with margin, before the unit is quiet
  localparam int SETTLE_CYCLES = 16;
  // far beyond the slowest legal run
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 10;

  // one expected sample request result
  typedef struct {
    logic [15:0] sample;
    logic        active;
    logic        last;
  } tone_sample_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [bfsk_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bfsk_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [7:0]                      in_tdata;   // [7:0] byte_value
  logic                            in_tuser;   // [0] kind
  logic                            out_tvalid;
  logic                            out_tready;
  logic [15:0]                     out_tdata;  // [15:0] sample
  logic                            out_tuser;  // [0] active
  logic                            out_tlast;  // last_of_byte

  // register copies held by the predictor
  logic [15:0] spb_cfg;
  logic [31:0] zero_step_cfg;
  logic [31:0] one_step_cfg;

  // byte sender state held by the predictor
  logic [7:0]  shift_bits;
  logic [3:0]  bits_to_go;
  logic [15:0] tick_in_bit;
  logic [31:0] tone_phase;
  logic        sending;

  tone_sample_t expected_samples[$];
  tone_sample_t want;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int samples_checked;
  int bytes_loaded;
  int cfg_writes;
  int cycle_count;

  bfsk_tone_modulator_unit #(
    .SINE_TABLE_ENTRIES(32'(TABLE_N))
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // run guard: a hang or a lost sample ends here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples still expected", cycle_count,
               expected_samples.size());
      $display("tb_bfsk_tone_modulator_unit failed");
      $finish;
    end
  end

  // sample sink: stalls at the requested rate, changes at the falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // quantize phase to the table, fold to a quarter turn, evaluate the
  // polynomial sine in q30 and scale to q1.15
  function automatic logic [15:0] tone_sine(logic [31:0] ph);
    longint unsigned slot, angle, h, x, x2, t, t2, y, mag;
    slot  = ({32'd0, ph} * TABLE_N) >> 32;
    angle = (slot << 32) / TABLE_N;
    h     = angle & 64'h7FFF_FFFF;
    if (h > QUARTER_TURN) begin
      h = 64'h8000_0000 - h;
    end
    x   = h;
    x2  = (x * x) >> 30;
    t   = POLY_B - ((x2 * POLY_C) >> 30);
    t2  = POLY_A - ((x2 * t) >> 30);
    y   = (x * t2) >> 30;
    mag = (y * PEAK + 64'd536870912) >> 30;
    if (mag > PEAK) begin
      mag = PEAK;
    end
    // lower half turn gives the negative lobe
    if (angle[31]) begin
      return 16'd0 - mag[15:0];
    end
    return mag[15:0];
  endfunction

  // advance the predictor by one accepted request; returns 1 unless a load
  // was dropped because a byte is still going out
  function automatic bit tone_advance(logic kind, logic [7:0] value);
    tone_sample_t s;
    logic [15:0]  limit;
    if (kind == bfsk_pkg::KIND_LOAD) begin
      if (sending) begin
        return 1'b0;
      end
      shift_bits  = value;
      bits_to_go  = bfsk_pkg::BITS_PER_BYTE;
      tick_in_bit = '0;
      tone_phase  = '0;
      sending     = 1'b1;
      bytes_loaded++;
      return 1'b1;
    end
    s.sample = '0;
    s.active = 1'b0;
    s.last   = 1'b0;
    if (sending) begin
      s.sample    = tone_sine(tone_phase);
      s.active    = 1'b1;
      tone_phase  = tone_phase + (shift_bits[7] ? one_step_cfg : zero_step_cfg);
      tick_in_bit = tick_in_bit + 16'd1;
      // a zero bit length acts as one sample per bit
      limit = (spb_cfg == 16'd0) ? 16'd1 : spb_cfg;
      // also ends a bit whose length was cut below the count mid-bit
      if (tick_in_bit >= limit || tick_in_bit == 16'd0) begin
        tick_in_bit = '0;
        tone_phase  = '0;
        shift_bits  = {shift_bits[6:0], 1'b0};
        bits_to_go  = bits_to_go - 4'd1;
        if (bits_to_go == 4'd0) begin
          sending = 1'b0;
          s.last  = 1'b1;
        end
      end
    end
    expected_samples.push_back(s);
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
  endtask

  // sample checker: every accepted sample against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected sample %h active %b last %b",
                                  out_tdata, out_tuser, out_tlast));
      end else begin
        want = expected_samples.pop_front();
        samples_checked++;
        if (out_tdata !== want.sample) begin
          report_mismatch($sformatf("sample expected %h got %h", want.sample, out_tdata));
        end
        if (out_tuser !== want.active) begin
          report_mismatch($sformatf("active expected %b got %b", want.active, out_tuser));
        end
        if (out_tlast !== want.last) begin
          report_mismatch($sformatf("last_of_byte expected %b got %b", want.last, out_tlast));
        end
      end
    end
  end

  // one request: optional idle gap, then hold valid until accepted;
  // entered and left just after a falling edge
  task automatic send_request(logic kind, logic [7:0] value, output bit counted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = value;
    do begin
      @(posedge clk);
    end while (!in_tready);
    counted = tone_advance(kind, value);
    @(negedge clk);
  endtask

  // stop sending, let every expected sample out, then let loads settle
  task automatic drain_pipeline();
    in_tvalid = 1'b0;
    while (expected_samples.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write, only called once the unit is drained
  task automatic write_register(logic [bfsk_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_writes++;
    case (idx)
      bfsk_pkg::REG_SAMPLES_PER_BIT: spb_cfg = value[15:0];
      bfsk_pkg::REG_STEP_FOR_ZERO:   zero_step_cfg = value;
      bfsk_pkg::REG_STEP_FOR_ONE:    one_step_cfg = value;
      default: ;
    endcase
  endtask

  // tick until the byte in flight has gone out
  task automatic finish_byte();
    bit counted;
    while (sending) begin
      send_request(bfsk_pkg::KIND_TICK, 8'($urandom), counted);
    end
  endtask

  function automatic logic [31:0] pick_step();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(1, 64)) << 22;  // whole table slots
      default: return $urandom;
    endcase
  endfunction

  // short bit lengths keep bytes cheap; both steps and sometimes the
  // unused index get new values
  task automatic random_config();
    drain_pipeline();
    case ($urandom_range(3))
      0: write_register(bfsk_pkg::REG_SAMPLES_PER_BIT, 32'd0);
      1: write_register(bfsk_pkg::REG_SAMPLES_PER_BIT, 32'd1);
      default: write_register(bfsk_pkg::REG_SAMPLES_PER_BIT, 32'($urandom_range(2, 6)));
    endcase
    write_register(bfsk_pkg::REG_STEP_FOR_ZERO, pick_step());
    write_register(bfsk_pkg::REG_STEP_FOR_ONE, pick_step());
    if ($urandom_range(3) == 0) begin
      write_register(REG_UNUSED, $urandom);
    end
  endtask

  // reset register values: idle tick, a byte with both tones, a load while
  // busy, then bit length cut to zero (acts as one) below the running count
  task automatic test_reset_values();
    bit counted;
    send_request(bfsk_pkg::KIND_TICK, 8'h00, counted);
    send_request(bfsk_pkg::KIND_LOAD, 8'hA5, counted);
    repeat (3) send_request(bfsk_pkg::KIND_TICK, 8'h00, counted);
    send_request(bfsk_pkg::KIND_LOAD, 8'h3C, counted);
    drain_pipeline();
    write_register(bfsk_pkg::REG_SAMPLES_PER_BIT, 32'd0);
    finish_byte();
    send_request(bfsk_pkg::KIND_TICK, 8'hFF, counted);
  endtask

  // widest bit length, all-ones and zero steps, a write to the unused index,
  // then a cut to one sample per bit mid-bit
  task automatic test_register_extremes();
    bit counted;
    drain_pipeline();
    write_register(bfsk_pkg::REG_SAMPLES_PER_BIT, 32'd65535);
    write_register(bfsk_pkg::REG_STEP_FOR_ZERO, 32'hFFFF_FFFF);
    write_register(bfsk_pkg::REG_STEP_FOR_ONE, 32'h0000_0000);
    write_register(REG_UNUSED, 32'hFFFF_FFFF);
    send_request(bfsk_pkg::KIND_LOAD, 8'h5A, counted);
    repeat (3) send_request(bfsk_pkg::KIND_TICK, 8'h00, counted);
    drain_pipeline();
    write_register(bfsk_pkg::REG_SAMPLES_PER_BIT, 32'd1);
    finish_byte();
  endtask

  // mostly whole bytes with random content, some cut short and sometimes
  // reconfigured mid-byte, the rest random noise requests
  task automatic test_random_traffic(int n_items, int send_pct, int recv_pct);
    int  done_items;
    int  pick;
    int  cut;
    bit  counted;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    random_config();
    done_items = 0;
    while (done_items < n_items) begin
      if ($urandom_range(99) < 4) begin
        random_config();
      end
      pick = $urandom_range(99);
      if (pick < 75) begin
        // whole byte, now and then a dropped load in the middle
        send_request(bfsk_pkg::KIND_LOAD, 8'($urandom), counted);
        if (counted) done_items++;
        while (sending) begin
          if ($urandom_range(99) < 3) begin
            send_request(bfsk_pkg::KIND_LOAD, 8'($urandom), counted);
          end else begin
            send_request(bfsk_pkg::KIND_TICK, 8'($urandom), counted);
            done_items++;
          end
        end
      end else if (pick < 90) begin
        // byte cut short, sometimes with new registers mid-byte
        send_request(bfsk_pkg::KIND_LOAD, 8'($urandom), counted);
        if (counted) done_items++;
        cut = $urandom_range(0, 8);
        repeat (cut) begin
          send_request(bfsk_pkg::KIND_TICK, 8'($urandom), counted);
          done_items++;
        end
        if ($urandom_range(1) == 1) begin
          random_config();
        end
      end else begin
        send_request(1'($urandom), 8'($urandom), counted);
        if (counted) done_items++;
      end
    end
    drain_pipeline();
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = bfsk_pkg::KIND_TICK;
    out_tready    = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    mismatches      = 0;
    samples_checked = 0;
    bytes_loaded    = 0;
    cfg_writes      = 0;
    cycle_count     = 0;
    spb_cfg       = bfsk_pkg::SPB_RESET;
    zero_step_cfg = bfsk_pkg::STEP_ZERO_RESET;
    one_step_cfg  = bfsk_pkg::STEP_ONE_RESET;
    shift_bits    = '0;
    bits_to_go    = '0;
    tick_in_bit   = '0;
    tone_phase    = '0;
    sending       = 1'b0;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_values();
    test_register_extremes();
    // sender slow and receiver stalling, then swapped, then full rate
    test_random_traffic(570, 29, 88);
    test_random_traffic(570, 88, 29);
    test_random_traffic(570, 0, 0);

    drain_pipeline();
    $display("checked %0d samples from %0d loaded bytes across %0d register writes",
             samples_checked, bytes_loaded, cfg_writes);
    $display("%0d mismatches, %0d clock cycles", mismatches, cycle_count);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("tb_bfsk_tone_modulator_unit passed");
    end else begin
      $display("tb_bfsk_tone_modulator_unit failed");
    end
    $finish;
  end

endmodule

### bfsk_tone_modulator_unit.f
src/bfsk_pkg.sv
src/bfsk_queue.sv
src/bfsk_front.sv
src/bfsk_sine.sv
src/bfsk_tone_modulator_unit.sv
tb/tb_bfsk_tone_modulator_unit.sv
